// ===== hdl/first_fit_heap_allocator_assert.svh =====
// Assertion macros for the first-fit heap allocator.
// Used by the top level; no other dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
// check that a condition implies a consequence in the same cycle
`define FFHA_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// check that a condition implies a consequence in the next cycle
`define FFHA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: sizes, codes, item types.
// No dependencies.
`timescale 1ns / 1ps
package ffha_pkg;
    localparam int HEAP_BYTES  = 8388608;
    localparam int ALIGN_BYTES = 16;
    localparam int MAX_BLOCKS  = 256;
    localparam int ALIGN_W     = $clog2(ALIGN_BYTES);
    localparam int HEAP_GRAN   = HEAP_BYTES / ALIGN_BYTES;
    // hold a full-size request in granules plus the bump pointer
    localparam int GW          = $clog2(HEAP_GRAN) + 2;
    localparam int IW          = $clog2(MAX_BLOCKS);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOMEM    = 3'd1;
    localparam logic [2:0] ST_NOTHEAP  = 3'd2;
    localparam logic [2:0] ST_NOTALLOC = 3'd3;
    localparam logic [2:0] ST_DOUBLE   = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_NULL     = 3'd6;

    typedef struct packed {
        logic        mode;
        logic [23:0] req_bytes;
        logic [22:0] address;
        logic        null_pointer;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [22:0] result_address;
        logic [31:0] active_count;
        logic [31:0] total_count;
        logic [31:0] fail_count;
        logic [23:0] active_bytes;
        logic [39:0] total_bytes;
        logic [39:0] fail_bytes;
    } t_out_item;

    typedef struct packed {
        logic [GW-1:0] start;
        logic [GW-1:0] gran;
        logic [23:0]   req;
        logic          is_free;
    } t_blk;

    typedef struct packed {
        logic          we;
        logic [IW-1:0] waddr;
        t_blk          wdata;
        logic [IW-1:0] raddr;
    } t_mem_req;
endpackage

// ===== hdl/ffha_table.sv =====
// Block table memory: one write port, one registered read port.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_table (
    input  logic              i_clk,
    input  ffha_pkg::t_mem_req i_req,
    output ffha_pkg::t_blk    o_rdata
);
    ffha_pkg::t_blk r_mem [ffha_pkg::MAX_BLOCKS];
    ffha_pkg::t_blk r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator top level: sequencer, valid bits, statistics.
// Depends on ffha_pkg, ffha_table and first_fit_heap_allocator_assert.svh.
//
// Usage:
//   Input channel i_valid/o_stall carries one request item (allocate or
//   free). Output channel o_valid/i_stall carries one result item per
//   request, with status, granted address and six statistics.
//   The block works on one item at a time. o_stall is high from accept
//   until the result has been taken, and during reset.
//   Path of an item: a null free, or a free rejected by the bound or
//   alignment check, goes from decode straight to output. A bump allocate
//   or a table-full reject passes through S_ARD. An allocate past the
//   bump space scans the table once; S_ASPL then reports no fit, or grants
//   and writes the block back in S_FW3. A free scans once for the block
//   and its left neighbor, and S_FCHK rejects a bad free. A good free scans
//   again for the right neighbor, then merges left in S_FW2 or else writes
//   the block in S_FW3. The scans read one table entry per cycle.
//   The next item is accepted only after the result has been taken.
//   Reset clears the valid bits, the bump pointer and all statistics at
//   once; no clearing pass is needed.
//   While the receiver stalls, the result item is held and no new request
//   is accepted.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
module first_fit_heap_allocator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  ffha_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output ffha_pkg::t_out_item   o_item
);
    localparam int GW = ffha_pkg::GW;
    localparam int IW = ffha_pkg::IW;
    localparam int CW = IW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_ASPL  = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_FW1   = 4'd5;
    localparam logic [3:0] S_FW2   = 4'd6;
    localparam logic [3:0] S_FW3   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_ARD   = 4'd9;

    typedef ffha_pkg::t_blk t_blk_t;

    logic [3:0]            r_state, n_state;
    logic [ffha_pkg::MAX_BLOCKS-1:0] r_valid, n_valid;
    logic [GW-1:0]         r_bump, n_bump;
    logic [23:0]           r_top, n_top;
    logic [31:0]           r_act, n_act, r_tot, n_tot, r_fail, n_fail;
    logic [23:0]           r_actb, n_actb;
    logic [39:0]           r_totb, n_totb, r_failb, n_failb;
    ffha_pkg::t_in_item    r_in, n_in;
    logic [GW-1:0]         r_g, n_g;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_ridx, n_ridx;
    logic                  r_rv, n_rv;
    logic                  r_hit, n_hit;
    logic [IW-1:0]         r_bi, n_bi;
    t_blk_t                r_b, n_b;
    logic                  r_nh, n_nh;
    logic [GW-1:0]         r_ng, n_ng;
    logic                  r_ph, n_ph;
    logic [IW-1:0]         r_pi, n_pi;
    t_blk_t                r_p, n_p;
    logic                  r_fs, n_fs;
    logic [IW-1:0]         r_fsi, n_fsi;
    logic [2:0]            r_st, n_st;
    logic [22:0]           r_ra, n_ra;
    logic                  r_ov, n_ov;

    ffha_pkg::t_mem_req    s_mreq;
    t_blk_t                s_rd;
    logic [23:0]           s_rsum;
    logic [GW-1:0]         s_g;
    logic [GW-1:0]         s_bsum;
    logic [GW-1:0]         s_rend;
    logic                  s_fs;
    logic [IW-1:0]         s_fsi;

    ffha_table u_table (
        .i_clk  (i_clk),
        .i_req  (s_mreq),
        .o_rdata(s_rd)
    );

    always_comb begin
        s_fs  = 1'b0;
        s_fsi = '0;
        for (int k = ffha_pkg::MAX_BLOCKS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                s_fs  = 1'b1;
                s_fsi = IW'(k);
            end
        end
    end

    assign s_rsum = r_in.req_bytes + 24'(ffha_pkg::ALIGN_BYTES - 1);
    assign s_g    = (r_in.req_bytes == '0) ? GW'(1) :
                    GW'({(r_in.req_bytes > 24'(24'hFFFFFF - ffha_pkg::ALIGN_BYTES + 1)),
                         s_rsum} >> ffha_pkg::ALIGN_W);
    assign s_bsum = r_bump + r_g;
    assign s_rend = s_rd.start + s_rd.gran;

    function automatic logic [31:0] f_inc32(input logic [31:0] a);
        f_inc32 = (a == '1) ? a : a + 32'd1;
    endfunction

    function automatic logic [39:0] f_add40(input logic [39:0] a, input logic [23:0] b);
        logic [40:0] s;
        s = {1'b0, a} + 41'(b);
        f_add40 = s[40] ? '1 : s[39:0];
    endfunction

    always_comb begin
        logic [24:0] sb;
        n_state = r_state; n_valid = r_valid; n_bump = r_bump; n_top = r_top;
        n_act = r_act; n_tot = r_tot; n_fail = r_fail;
        n_actb = r_actb; n_totb = r_totb; n_failb = r_failb;
        n_in = r_in; n_g = r_g; n_cnt = r_cnt; n_ridx = r_ridx; n_rv = r_rv;
        n_hit = r_hit; n_bi = r_bi; n_b = r_b; n_nh = r_nh; n_ng = r_ng;
        n_ph = r_ph; n_pi = r_pi; n_p = r_p; n_fs = r_fs; n_fsi = r_fsi;
        n_st = r_st; n_ra = r_ra; n_ov = r_ov;
        s_mreq = '0;
        s_mreq.raddr = r_cnt[IW-1:0];
        sb = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in = i_item;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_g = s_g;
                n_cnt = '0;
                n_rv = 1'b0;
                n_hit = 1'b0; n_nh = 1'b0; n_ph = 1'b0;
                n_ra = '0;
                n_fs = s_fs; n_fsi = s_fsi;
                if (r_in.mode == 1'b0) begin
                    n_state = S_ARD;
                end else if (r_in.null_pointer) begin
                    n_st = ffha_pkg::ST_NULL;
                    n_state = S_OUT;
                end else if ({1'b0, r_in.address} > r_top) begin
                    n_st = ffha_pkg::ST_NOTHEAP;
                    n_state = S_OUT;
                end else if (r_in.address[ffha_pkg::ALIGN_W-1:0] != '0) begin
                    n_st = ffha_pkg::ST_NOTALLOC;
                    n_state = S_OUT;
                end else begin
                    n_g = GW'(r_in.address >> ffha_pkg::ALIGN_W);
                    n_state = S_SCAN;
                end
            end
            S_ARD: begin
                if ({1'b0, s_bsum} <= (GW + 1)'(ffha_pkg::HEAP_GRAN)) begin
                    if (!r_fs) begin
                        n_st = ffha_pkg::ST_FULL;
                        n_fail = f_inc32(r_fail);
                        n_failb = f_add40(r_failb, r_in.req_bytes);
                    end else begin
                        s_mreq.we = 1'b1;
                        s_mreq.waddr = r_fsi;
                        s_mreq.wdata = '{start: r_bump, gran: r_g,
                                         req: r_in.req_bytes, is_free: 1'b0};
                        n_valid[r_fsi] = 1'b1;
                        n_top = 24'({r_bump, {ffha_pkg::ALIGN_W{1'b0}}}) + r_in.req_bytes;
                        n_bump = s_bsum;
                        n_ra = 23'({r_bump, {ffha_pkg::ALIGN_W{1'b0}}});
                        n_st = ffha_pkg::ST_OK;
                        n_act = f_inc32(r_act); n_tot = f_inc32(r_tot);
                        sb = {1'b0, r_actb} + {1'b0, r_in.req_bytes};
                        n_actb = sb[24] ? '1 : sb[23:0];
                        n_totb = f_add40(r_totb, r_in.req_bytes);
                    end
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt != CW'(ffha_pkg::MAX_BLOCKS)) begin
                    n_cnt = r_cnt + CW'(1);
                end
                n_rv = (r_cnt != CW'(ffha_pkg::MAX_BLOCKS)) && r_valid[r_cnt[IW-1:0]];
                n_ridx = r_cnt;
                if (r_rv) begin
                    if (r_in.mode == 1'b0) begin
                        if (s_rd.is_free && s_rd.gran >= r_g &&
                            (!r_hit || s_rd.start < r_b.start)) begin
                            n_hit = 1'b1; n_bi = r_ridx[IW-1:0]; n_b = s_rd;
                        end
                    end else begin
                        if (!r_hit && s_rd.start == r_g) begin
                            n_hit = 1'b1; n_bi = r_ridx[IW-1:0]; n_b = s_rd;
                        end
                        if (!r_ph && s_rend == r_g) begin
                            n_ph = 1'b1; n_pi = r_ridx[IW-1:0]; n_p = s_rd;
                        end
                    end
                end
                if (r_cnt == CW'(ffha_pkg::MAX_BLOCKS) && !r_rv && r_ridx ==
                    CW'(ffha_pkg::MAX_BLOCKS)) begin
                    n_state = (r_in.mode == 1'b0) ? S_ASPL : S_FCHK;
                    n_cnt = '0;
                end
            end
            S_ASPL: begin
                if (!r_hit) begin
                    n_st = ffha_pkg::ST_NOMEM;
                    n_fail = f_inc32(r_fail);
                    n_failb = f_add40(r_failb, r_in.req_bytes);
                    n_state = S_OUT;
                end else begin
                    n_b.is_free = 1'b0;
                    n_b.req = r_in.req_bytes;
                    if (r_b.gran > r_g && r_fs) begin
                        s_mreq.we = 1'b1;
                        s_mreq.waddr = r_fsi;
                        s_mreq.wdata = '{start: r_b.start + r_g, gran: r_b.gran - r_g,
                                         req: 24'd0, is_free: 1'b1};
                        n_valid[r_fsi] = 1'b1;
                        n_b.gran = r_g;
                    end
                    n_ra = 23'({r_b.start, {ffha_pkg::ALIGN_W{1'b0}}});
                    n_st = ffha_pkg::ST_OK;
                    n_act = f_inc32(r_act); n_tot = f_inc32(r_tot);
                    sb = {1'b0, r_actb} + {1'b0, r_in.req_bytes};
                    n_actb = sb[24] ? '1 : sb[23:0];
                    n_totb = f_add40(r_totb, r_in.req_bytes);
                    n_state = S_FW3;
                end
            end
            S_FW3: begin
                s_mreq.we = 1'b1;
                s_mreq.waddr = r_bi;
                s_mreq.wdata = r_b;
                n_state = S_OUT;
            end
            S_FCHK: begin
                if (!r_hit) begin
                    n_st = ffha_pkg::ST_NOTALLOC;
                    n_state = S_OUT;
                end else if (r_b.is_free) begin
                    n_st = ffha_pkg::ST_DOUBLE;
                    n_state = S_OUT;
                end else begin
                    n_st = ffha_pkg::ST_OK;
                    if (r_act != '0) n_act = r_act - 32'd1;
                    n_actb = (r_actb >= r_b.req) ? r_actb - r_b.req : '0;
                    n_b.is_free = 1'b1;
                    n_ng = r_b.start + r_b.gran;
                    n_cnt = '0; n_rv = 1'b0; n_nh = 1'b0;
                    n_state = S_FW1;
                end
            end
            S_FW1: begin
                // second pass: find block starting at the end of the freed one
                if (r_cnt != CW'(ffha_pkg::MAX_BLOCKS)) begin
                    n_cnt = r_cnt + CW'(1);
                end
                n_rv = (r_cnt != CW'(ffha_pkg::MAX_BLOCKS)) && r_valid[r_cnt[IW-1:0]];
                n_ridx = r_cnt;
                if (r_rv && !r_nh && s_rd.start == r_ng) begin
                    n_nh = 1'b1;
                    if (r_ridx[IW-1:0] != r_bi && s_rd.is_free) begin
                        n_b.gran = r_b.gran + s_rd.gran;
                        n_valid[r_ridx[IW-1:0]] = 1'b0;
                        if (r_ph && r_pi == r_ridx[IW-1:0]) n_ph = 1'b0;
                    end
                end
                if (r_cnt == CW'(ffha_pkg::MAX_BLOCKS) && !r_rv && r_ridx ==
                    CW'(ffha_pkg::MAX_BLOCKS)) begin
                    n_state = S_FW2;
                end
            end
            S_FW2: begin
                if (r_ph && r_pi != r_bi && r_p.is_free) begin
                    s_mreq.we = 1'b1;
                    s_mreq.waddr = r_pi;
                    s_mreq.wdata = '{start: r_p.start, gran: r_p.gran + r_b.gran,
                                     req: r_p.req, is_free: 1'b1};
                    n_valid[r_bi] = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_FW3;
                end
            end
            S_OUT: begin
                n_ov = 1'b1;
                if (r_ov && !i_stall) begin
                    n_ov = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_bump <= '0; r_top <= '0;
            r_act <= '0; r_tot <= '0; r_fail <= '0;
            r_actb <= '0; r_totb <= '0; r_failb <= '0;
            r_ov <= 1'b0; r_rv <= 1'b0; r_cnt <= '0; r_ridx <= '0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_bump <= n_bump; r_top <= n_top;
            r_act <= n_act; r_tot <= n_tot; r_fail <= n_fail;
            r_actb <= n_actb; r_totb <= n_totb; r_failb <= n_failb;
            r_ov <= n_ov; r_rv <= n_rv; r_cnt <= n_cnt; r_ridx <= n_ridx;
        end
        r_in <= n_in; r_g <= n_g; r_hit <= n_hit; r_bi <= n_bi; r_b <= n_b;
        r_nh <= n_nh; r_ng <= n_ng; r_ph <= n_ph; r_pi <= n_pi;
        r_p <= n_p; r_fs <= n_fs; r_fsi <= n_fsi; r_st <= n_st; r_ra <= n_ra;
    end

    assign o_stall = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid = r_ov;
    assign o_item  = '{status: r_st, result_address: r_ra, active_count: r_act,
                       total_count: r_tot, fail_count: r_fail, active_bytes: r_actb,
                       total_bytes: r_totb, fail_bytes: r_failb};

    `FFHA_ASSERT_IMP(a_valid_out_state, i_clk, i_rst_n, o_valid, r_state == S_OUT,
        "result item shown outside output state")
    `FFHA_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_item), "stalled result item changed")
    `FFHA_ASSERT_NEXT(a_bump_mono, i_clk, i_rst_n, 1'b1, r_bump >= $past(r_bump),
        "bump pointer moved back")
    `FFHA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall,
        "request taken while busy")
endmodule

// ===== bench/first_fit_heap_allocator_test.sv =====
// Testbench for first_fit_heap_allocator: directed table, then random allocate and free traffic.
// Results are checked against an in-bench heap predictor; depends on ffha_pkg and the RTL.
`timescale 1ns / 1ps
module first_fit_heap_allocator_test;
    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  HOLD_CYCLES    = 2000;
    localparam longint M24 = 64'hFF_FFFF;
    localparam longint M32 = 64'hFFFF_FFFF;
    localparam longint M40 = 64'hFF_FFFF_FFFF;
    localparam int  S_ACT = 0, S_TOT = 1, S_FAIL = 2, S_ACTB = 3, S_TOTB = 4, S_FAILB = 5;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_valid = 0;
    logic                o_stall;
    ffha_pkg::t_in_item  i_item = '0;
    logic                o_valid;
    logic                i_stall = 0;
    ffha_pkg::t_out_item o_item;

    first_fit_heap_allocator uut (.*);

    always #1 i_clk = ~i_clk;

    // heap predictor state
    longint blk_at_g[ffha_pkg::MAX_BLOCKS];
    longint blk_len[ffha_pkg::MAX_BLOCKS];
    longint blk_bytes[ffha_pkg::MAX_BLOCKS];
    bit     blk_free[ffha_pkg::MAX_BLOCKS];
    bit     blk_live[ffha_pkg::MAX_BLOCKS];
    longint next_gran, top_byte;
    longint stats[6];

    ffha_pkg::t_out_item want_q[$];
    int  errors = 0, sent = 0, taken = 0, quiet = 0;
    int  src_idle = 0, snk_idle = 0;
    bit  hold_req = 0;
    int  hold_cnt = 0;

    function automatic longint sat_add(longint a, longint b, longint mx);
        if (b > mx || a > mx - b) return mx;
        return a + b;
    endfunction

    function automatic int open_slot();
        for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++) if (!blk_live[i]) return i;
        return -1;
    endfunction

    function automatic int block_starting(longint g);
        for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++)
            if (blk_live[i] && blk_at_g[i] == g) return i;
        return -1;
    endfunction

    function automatic int block_ending(longint g);
        for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++)
            if (blk_live[i] && blk_at_g[i] + blk_len[i] == g) return i;
        return -1;
    endfunction

    function automatic void note_fail(longint req);
        stats[S_FAIL]  = sat_add(stats[S_FAIL], 1, M32);
        stats[S_FAILB] = sat_add(stats[S_FAILB], req, M40);
    endfunction

    function automatic void note_ok(longint req);
        stats[S_ACT]  = sat_add(stats[S_ACT], 1, M32);
        stats[S_TOT]  = sat_add(stats[S_TOT], 1, M32);
        stats[S_ACTB] = sat_add(stats[S_ACTB], req, M24);
        stats[S_TOTB] = sat_add(stats[S_TOTB], req, M40);
    endfunction

    function automatic logic [2:0] grant_block(longint req, output longint addr);
        longint g;
        int     s, best;
        g = (req + ffha_pkg::ALIGN_BYTES - 1) / ffha_pkg::ALIGN_BYTES;
        best = -1;
        addr = 0;
        if (g == 0) g = 1;
        if (next_gran + g <= ffha_pkg::HEAP_GRAN) begin
            s = open_slot();
            if (s < 0) begin
                note_fail(req);
                return ffha_pkg::ST_FULL;
            end
            blk_at_g[s] = next_gran; blk_len[s] = g; blk_bytes[s] = req;
            blk_free[s] = 0; blk_live[s] = 1;
            top_byte = next_gran * ffha_pkg::ALIGN_BYTES + req;
            next_gran += g;
            addr = blk_at_g[s] * ffha_pkg::ALIGN_BYTES;
            note_ok(req);
            return ffha_pkg::ST_OK;
        end
        for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++)
            if (blk_live[i] && blk_free[i] && blk_len[i] >= g &&
                (best < 0 || blk_at_g[i] < blk_at_g[best])) best = i;
        if (best < 0) begin
            note_fail(req);
            return ffha_pkg::ST_NOMEM;
        end
        if (blk_len[best] > g) begin
            s = open_slot();
            if (s >= 0) begin
                blk_at_g[s] = blk_at_g[best] + g; blk_len[s] = blk_len[best] - g;
                blk_bytes[s] = 0; blk_free[s] = 1; blk_live[s] = 1;
                blk_len[best] = g;
            end
        end
        blk_free[best] = 0;
        blk_bytes[best] = req;
        addr = blk_at_g[best] * ffha_pkg::ALIGN_BYTES;
        note_ok(req);
        return ffha_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] release_block(longint addr);
        int b, n, p;
        if (addr > top_byte) return ffha_pkg::ST_NOTHEAP;
        if (addr % ffha_pkg::ALIGN_BYTES != 0) return ffha_pkg::ST_NOTALLOC;
        b = block_starting(addr / ffha_pkg::ALIGN_BYTES);
        if (b < 0) return ffha_pkg::ST_NOTALLOC;
        if (blk_free[b]) return ffha_pkg::ST_DOUBLE;
        if (stats[S_ACT] > 0) stats[S_ACT]--;
        stats[S_ACTB] = (stats[S_ACTB] >= blk_bytes[b]) ? stats[S_ACTB] - blk_bytes[b] : 0;
        blk_free[b] = 1;
        n = block_starting(blk_at_g[b] + blk_len[b]);
        if (n >= 0 && n != b && blk_free[n]) begin
            blk_len[b] += blk_len[n];
            blk_live[n] = 0;
        end
        p = block_ending(blk_at_g[b]);
        if (p >= 0 && p != b && blk_free[p]) begin
            blk_len[p] += blk_len[b];
            blk_live[b] = 0;
        end
        return ffha_pkg::ST_OK;
    endfunction

    function automatic ffha_pkg::t_out_item heap_step(ffha_pkg::t_in_item it);
        ffha_pkg::t_out_item r;
        longint    ra;
        ra = 0;
        r = '0;
        if (!it.mode) r.status = grant_block(it.req_bytes, ra);
        else if (it.null_pointer) r.status = ffha_pkg::ST_NULL;
        else r.status = release_block(it.address);
        r.result_address = ra[22:0];
        r.active_count   = stats[S_ACT][31:0];
        r.total_count    = stats[S_TOT][31:0];
        r.fail_count     = stats[S_FAIL][31:0];
        r.active_bytes   = stats[S_ACTB][23:0];
        r.total_bytes    = stats[S_TOTB][39:0];
        r.fail_bytes     = stats[S_FAILB][39:0];
        return r;
    endfunction

    // pick the start of a random block, allocated or free
    function automatic longint pick_block(bit want_free);
        int idx[$];
        for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++)
            if (blk_live[i] && blk_free[i] == want_free) idx.push_back(i);
        if (idx.size() == 0) return longint'($urandom_range(0, 8388607));
        return blk_at_g[idx[$urandom_range(0, idx.size() - 1)]] * ffha_pkg::ALIGN_BYTES;
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp);
        errors++;
        $display("mismatch on result %0d: %s got %0h expected %0h", taken, what, got, exp);
    endtask

    task automatic send_item(ffha_pkg::t_in_item it, bit typed, logic [2:0] st,
                             logic [22:0] ad);
        ffha_pkg::t_out_item w;
        while ($urandom_range(0, 99) < src_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        w = heap_step(it);
        if (typed) begin
            w.status = st;
            w.result_address = ad;
        end
        want_q.push_back(w);
        sent++;
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < snk_idle);
        end
    end

    always @(posedge i_clk) begin
        ffha_pkg::t_out_item w;
        if (i_rst_n && o_valid && !i_stall) begin
            taken++;
            if (want_q.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                w = want_q.pop_front();
                if (o_item.status != w.status)
                    report_mismatch("status", o_item.status, w.status);
                if (o_item.result_address != w.result_address)
                    report_mismatch("result_address", o_item.result_address, w.result_address);
                if (o_item.active_count != w.active_count)
                    report_mismatch("active_count", o_item.active_count, w.active_count);
                if (o_item.total_count != w.total_count)
                    report_mismatch("total_count", o_item.total_count, w.total_count);
                if (o_item.fail_count != w.fail_count)
                    report_mismatch("fail_count", o_item.fail_count, w.fail_count);
                if (o_item.active_bytes != w.active_bytes)
                    report_mismatch("active_bytes", o_item.active_bytes, w.active_bytes);
                if (o_item.total_bytes != w.total_bytes)
                    report_mismatch("total_bytes", o_item.total_bytes, w.total_bytes);
                if (o_item.fail_bytes != w.fail_bytes)
                    report_mismatch("fail_bytes", o_item.fail_bytes, w.fail_bytes);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d items pending", want_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    typedef struct {
        ffha_pkg::t_in_item it;
        bit         typed;
        logic [2:0] st;
        logic [22:0] ad;
    } t_row;

    t_row rows[] = '{
        '{'{1'b1, 24'd0, 23'd0, 1'b1}, 1, ffha_pkg::ST_NULL, 23'd0},
        '{'{1'b1, 24'hFFFFFF, 23'h7FFFFF, 1'b1}, 1, ffha_pkg::ST_NULL, 23'd0},
        '{'{1'b1, 24'd0, 23'd0, 1'b0}, 1, ffha_pkg::ST_NOTALLOC, 23'd0},
        '{'{1'b1, 24'd0, 23'h7FFFFF, 1'b0}, 1, ffha_pkg::ST_NOTHEAP, 23'd0},
        '{'{1'b0, 24'd0, 23'd0, 1'b0}, 1, ffha_pkg::ST_OK, 23'd0},
        '{'{1'b0, 24'hFFFFFF, 23'h7FFFFF, 1'b0}, 1, ffha_pkg::ST_NOMEM, 23'd0},
        '{'{1'b0, 24'd100, 23'd0, 1'b0}, 1, ffha_pkg::ST_OK, 23'd16},
        '{'{1'b1, 24'd0, 23'd17, 1'b0}, 1, ffha_pkg::ST_NOTALLOC, 23'd0},
        '{'{1'b1, 24'd0, 23'd16, 1'b0}, 1, ffha_pkg::ST_OK, 23'd0},
        '{'{1'b1, 24'd0, 23'd16, 1'b0}, 1, ffha_pkg::ST_DOUBLE, 23'd0},
        '{'{1'b1, 24'd0, 23'd4096, 1'b0}, 1, ffha_pkg::ST_NOTHEAP, 23'd0},
        '{'{1'b0, 24'd1, 23'h7FFFFF, 1'b1}, 0, ffha_pkg::ST_OK, 23'd0},
        '{'{1'b1, 24'd0, 23'd0, 1'b0}, 0, ffha_pkg::ST_OK, 23'd0},
        '{'{1'b0, 24'd16, 23'd0, 1'b0}, 0, ffha_pkg::ST_OK, 23'd0},
        '{'{1'b0, 24'd17, 23'd0, 1'b0}, 0, ffha_pkg::ST_OK, 23'd0},
        '{'{1'b1, 24'd0, 23'd0, 1'b0}, 0, ffha_pkg::ST_OK, 23'd0}
    };

    task automatic random_items(int count, int alloc_pct, bit big);
        ffha_pkg::t_in_item it;
        int       k;
        for (int n = 0; n < count; n++) begin
            it = '0;
            it.mode = ($urandom_range(0, 99) >= alloc_pct);
            it.address = 23'($urandom_range(0, 8388607));
            it.req_bytes = 24'($urandom);
            if (!it.mode) begin
                k = $urandom_range(0, 9);
                if (!big || k < 5) it.req_bytes = 24'($urandom_range(0, 2048));
                else if (k < 9) it.req_bytes = 24'($urandom_range(65536, 2097152));
                it.null_pointer = $urandom_range(0, 1);
            end else begin
                k = $urandom_range(0, 19);
                if (k < 13) it.address = 23'(pick_block(0));
                else if (k < 15) it.address = 23'(pick_block(1));
                else if (k < 17) it.address = 23'(pick_block(0) + $urandom_range(1, 15));
                it.null_pointer = (k == 19);
            end
            send_item(it, 0, ffha_pkg::ST_OK, 23'd0);
        end
    endtask

    initial begin
        foreach (blk_live[i]) blk_live[i] = 0;
        next_gran = 0;
        top_byte  = 0;
        foreach (stats[i]) stats[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        src_idle = 32;
        snk_idle = 56;
        foreach (rows[r]) send_item(rows[r].it, rows[r].typed, rows[r].st, rows[r].ad);
        hold_req = 1;
        random_items(280, 98, 0);
        src_idle = 56;
        snk_idle = 32;
        random_items(130, 50, 1);
        src_idle = 0;
        snk_idle = 0;
        random_items(80, 60, 1);
        @(posedge i_clk);
        i_valid <= 0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("sent %0d items and checked %0d results: table fill, bump exhaustion,", sent, taken);
        $display("first-fit splits, coalescing frees and all free error cases");
        if (errors == 0 && want_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/ffha_pkg.sv
hdl/ffha_table.sv
hdl/first_fit_heap_allocator.sv
bench/first_fit_heap_allocator_test.sv
